/* rtl/core/ted_pkg.sv */
// Shared types, constants and helpers for the triggered exponential decay block.
package ted_pkg;

    // Default channel count
    localparam int CHANNELS_DEFAULT = 8;

    // Field widths
    localparam int OP_W    = 2;
    localparam int CHAN_W  = 3;
    localparam int SAMP_W  = 24;
    localparam int MS_W    = 24;
    localparam int ENV_W   = 32;
    localparam int SR_W    = 8;
    localparam int DIV_W   = 36;
    localparam int DIVR_W  = 32;

    // Opcodes
    localparam logic [OP_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OP_W-1:0] OP_BANG   = 2'd1;
    localparam logic [OP_W-1:0] OP_FLOAT  = 2'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd3;

    // Configuration register indexes
    localparam logic CFG_NORM_MODE = 1'b0;
    localparam logic CFG_SAMPLE_RATE = 1'b1;

    // Arithmetic constants
    localparam logic [DIV_W-1:0]  LOG2_1000_SHL8 = 36'd42802717696;
    localparam logic [31:0]       LN2_Q32        = 32'd2977044472;
    localparam logic [32:0]       ONE_Q32        = 33'h1_0000_0000;
    localparam logic signed [SAMP_W-1:0] ONE_Q20 = 24'sd1048576;
    localparam logic [7:0]        SR_RESET       = 8'd48;

    // Controller to datapath commands
    typedef struct packed {
        logic load;
        logic prep;
        logic div_start;
        logic div_k;
        logic mul_t;
        logic mul_p;
        logic upd_p;
        logic shift;
        logic mul_y;
        logic finish;
    } ted_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic is_sample;
        logic bypass;
        logic div_done;
        logic k_last;
        logic out_free;
    } ted_status_t;

    // Replace a value by its sign as plus or minus one
    function automatic logic signed [SAMP_W-1:0] sign_one(input logic signed [SAMP_W-1:0] v);
        sign_one = v[SAMP_W-1] ? -ONE_Q20 : ONE_Q20;
    endfunction

endpackage

/* rtl/core/ted_divider.sv */
// Restoring serial divider, one quotient bit per cycle.
module ted_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [ted_pkg::DIV_W-1:0]   dividend,
    input  logic [ted_pkg::DIVR_W-1:0]  divisor,
    output logic                        done,
    output logic [ted_pkg::DIV_W-1:0]   quotient
);
    import ted_pkg::*;

    localparam int CNT_W = $clog2(DIV_W + 1);

    logic [DIV_W-1:0]  quo_reg;
    logic [DIVR_W-1:0] rem_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DIVR_W:0]   trial;
    logic              fits;

    // Shift in the next dividend bit and try the subtraction
    always_comb begin
        trial = {rem_reg, quo_reg[DIV_W-1]};
        fits  = trial >= {1'b0, divisor};
    end

    // Hold control state and step the division
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_W'(DIV_W);
        end else if (busy_reg) begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == CNT_W'(1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    // Advance remainder and quotient
    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end else if (busy_reg) begin
            quo_reg <= {quo_reg[DIV_W-2:0], fits};
            rem_reg <= fits ? DIVR_W'(trial - {1'b0, divisor}) : trial[DIVR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

/* rtl/core/ted_datapath.sv */
// Datapath: channel state memories, coefficient arithmetic and output register.
module ted_datapath #(
    parameter int CHANNELS = ted_pkg::CHANNELS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  ted_pkg::ted_cmd_t                  cmd,
    output ted_pkg::ted_status_t               status,
    input  logic [ted_pkg::OP_W-1:0]           s_opcode,
    input  logic [ted_pkg::CHAN_W-1:0]         s_channel,
    input  logic signed [ted_pkg::SAMP_W-1:0]  s_sample,
    input  logic [ted_pkg::MS_W-1:0]           s_decay_ms,
    input  logic                               cfg_valid,
    input  logic                               cfg_index,
    input  logic [ted_pkg::SR_W-1:0]           cfg_data,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ted_pkg::CHAN_W-1:0]         m_out_channel,
    output logic signed [ted_pkg::SAMP_W-1:0]  m_out_value
);
    import ted_pkg::*;

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Configuration
    logic                     norm_reg;
    logic [SR_W-1:0]          sr_reg;

    // Item fields
    logic [CHAN_W-1:0]        ch_reg;
    logic [CH_W-1:0]          idx_reg;
    logic signed [SAMP_W-1:0] s_reg;
    logic [MS_W-1:0]          ms_reg;
    logic                     sample_ok_reg;

    // Channel state
    logic signed [SAMP_W-1:0] prev_mem [CHANNELS];
    logic signed [ENV_W-1:0]  env_mem  [CHANNELS];
    logic [CHANNELS-1:0]      valid_reg;
    logic signed [SAMP_W-1:0] prev_rd_reg;
    logic signed [ENV_W-1:0]  env_rd_reg;
    logic                     vld_rd_reg;

    // Pending trigger
    logic signed [SAMP_W-1:0] pend_val_reg;
    logic                     pend_armed_reg;

    // Arithmetic registers
    logic signed [SAMP_W-1:0] x_reg;
    logic signed [ENV_W-1:0]  env_reg;
    logic [31:0]              n_reg;
    logic [31:0]              t_reg;
    logic [11:0]              ip_reg;
    logic [32:0]              p_reg;
    logic [3:0]               k_reg;
    logic [63:0]              prod_reg;
    logic [31:0]              q_reg;
    logic [24:0]              a_reg;
    logic [56:0]              yprod_reg;
    logic                     neg_reg;

    // Output register
    logic                     m_valid_reg;
    logic [CHAN_W-1:0]        m_chan_reg;
    logic signed [SAMP_W-1:0] m_val_reg;

    // Combinational helpers
    logic [6:0]               ch_ext;
    logic [CH_W-1:0]          idx_in;
    logic                     in_range;
    logic [SR_W-1:0]          sr_eff;
    logic signed [SAMP_W-1:0] prev_eff;
    logic signed [ENV_W-1:0]  env_eff;
    logic                     trig;
    logic                     clr;
    logic signed [SAMP_W-1:0] x_new;
    logic [DIV_W-1:0]         div_dividend;
    logic [DIVR_W-1:0]        div_divisor;
    logic                     div_done;
    logic [DIV_W-1:0]         div_q;
    logic [32:0]              recip_m;
    logic [5:0]               recip_s;
    logic [64:0]              kprod;
    logic [55:0]              tprod;
    logic [31:0]              mag;
    logic [56:0]              rnd_full;
    logic signed [33:0]       rnd_s;
    logic signed [33:0]       y_wide;
    logic signed [ENV_W-1:0]  y32;
    logic signed [SAMP_W-1:0] y24;
    logic                     out_free;

    // Decode the incoming channel
    always_comb begin
        ch_ext   = {4'b0, s_channel};
        idx_in   = ch_ext[CH_W-1:0];
        in_range = ch_ext < 7'(CHANNELS);
        sr_eff   = (sr_reg == '0) ? SR_W'(1) : sr_reg;
        out_free = !m_valid_reg || m_ready;
    end

    // Resolve trigger, impulse and starting envelope
    always_comb begin
        prev_eff = vld_rd_reg ? prev_rd_reg : '0;
        env_eff  = vld_rd_reg ? env_rd_reg : '0;
        trig     = (s_reg != '0) && (prev_eff == '0);
        x_new    = '0;
        if (trig) begin
            x_new = norm_reg ? sign_one(s_reg) : s_reg;
        end
        if (pend_armed_reg) begin
            x_new = pend_val_reg;
        end
        clr = trig || pend_armed_reg;
    end

    // Divider operands for the exponent
    always_comb begin
        div_dividend = LOG2_1000_SHL8 + DIV_W'(n_reg >> 1);
        div_divisor  = n_reg;
    end

    ted_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (cmd.div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_q)
    );

    // Divide the series term by its index through a scaled reciprocal
    always_comb begin
        case (k_reg)
            4'd2: begin
                recip_m = 33'd4294967296;
                recip_s = 6'd33;
            end
            4'd3: begin
                recip_m = 33'd5726623062;
                recip_s = 6'd34;
            end
            4'd4: begin
                recip_m = 33'd4294967296;
                recip_s = 6'd34;
            end
            4'd5: begin
                recip_m = 33'd6871947674;
                recip_s = 6'd35;
            end
            4'd6: begin
                recip_m = 33'd5726623062;
                recip_s = 6'd35;
            end
            4'd7: begin
                recip_m = 33'd4908534053;
                recip_s = 6'd35;
            end
            4'd8: begin
                recip_m = 33'd4294967296;
                recip_s = 6'd35;
            end
            4'd9: begin
                recip_m = 33'd7635497416;
                recip_s = 6'd36;
            end
            4'd10: begin
                recip_m = 33'd6871947674;
                recip_s = 6'd36;
            end
            default: begin
                recip_m = 33'd4294967296;
                recip_s = 6'd32;
            end
        endcase
        kprod = 65'(prod_reg[63:32]) * 65'(recip_m);
    end

    // Round the product, add the impulse and saturate
    always_comb begin
        tprod    = 56'(div_q[23:0]) * 56'(LN2_Q32);
        mag      = env_reg[ENV_W-1] ? (32'd0 - 32'(env_reg)) : 32'(env_reg);
        rnd_full = yprod_reg + 57'h80_0000;
        rnd_s    = $signed({1'b0, rnd_full[56:24]});
        if (ms_reg == '0) begin
            y_wide = $signed({{10{x_reg[SAMP_W-1]}}, x_reg});
        end else begin
            y_wide = $signed({{10{x_reg[SAMP_W-1]}}, x_reg}) + (neg_reg ? -rnd_s : rnd_s);
        end
        if (y_wide > 34'sd2147483647) begin
            y32 = 32'sh7FFF_FFFF;
        end else if (y_wide < -34'sd2147483648) begin
            y32 = 32'sh8000_0000;
        end else begin
            y32 = y_wide[31:0];
        end
        if (y_wide > 34'sd8388607) begin
            y24 = 24'sh7F_FFFF;
        end else if (y_wide < -34'sd8388608) begin
            y24 = 24'sh80_0000;
        end else begin
            y24 = y_wide[23:0];
        end
    end

    // Hold configuration, pending trigger, valid bits and output handshake
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            norm_reg       <= 1'b0;
            sr_reg         <= SR_RESET;
            pend_val_reg   <= ONE_Q20;
            pend_armed_reg <= 1'b0;
            valid_reg      <= '0;
            sample_ok_reg  <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_valid) begin
                case (cfg_index)
                    CFG_NORM_MODE:   norm_reg <= cfg_data[0];
                    CFG_SAMPLE_RATE: sr_reg   <= cfg_data;
                    default:         norm_reg <= norm_reg;
                endcase
            end
            if (cmd.load) begin
                sample_ok_reg <= (s_opcode == OP_SAMPLE) && in_range;
                case (s_opcode)
                    OP_BANG: begin
                        pend_armed_reg <= 1'b1;
                    end
                    OP_FLOAT: begin
                        pend_val_reg   <= norm_reg ? sign_one(s_sample) : s_sample;
                        pend_armed_reg <= 1'b1;
                    end
                    OP_CLEAR: begin
                        valid_reg <= '0;
                    end
                    default: begin
                        pend_armed_reg <= pend_armed_reg;
                    end
                endcase
            end
            if (cmd.prep && sample_ok_reg) begin
                pend_armed_reg <= 1'b0;
            end
            if (cmd.finish) begin
                valid_reg[idx_reg] <= 1'b1;
            end
            if (cmd.finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Channel state memories: read at load, write at finish
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            prev_rd_reg <= prev_mem[idx_in];
            env_rd_reg  <= env_mem[idx_in];
            vld_rd_reg  <= valid_reg[idx_in];
        end
        if (cmd.finish) begin
            prev_mem[idx_reg] <= s_reg;
            env_mem[idx_reg]  <= (ms_reg == '0) ? env_reg : y32;
        end
    end

    // Advance the arithmetic registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            ch_reg  <= s_channel;
            idx_reg <= idx_in;
            s_reg   <= s_sample;
            ms_reg  <= s_decay_ms;
        end
        if (cmd.prep) begin
            x_reg   <= x_new;
            env_reg <= clr ? '0 : env_eff;
            n_reg   <= 32'(ms_reg) * 32'(sr_eff);
        end
        if (cmd.mul_t) begin
            t_reg  <= tprod[55:24];
            ip_reg <= div_q[35:24];
            p_reg  <= ONE_Q32;
            k_reg  <= 4'd10;
        end
        if (cmd.mul_p) begin
            prod_reg <= 64'(t_reg) * 64'(p_reg);
        end
        if (cmd.div_k) begin
            q_reg <= 32'(kprod >> recip_s);
        end
        if (cmd.upd_p) begin
            p_reg <= ONE_Q32 - {1'b0, q_reg};
            k_reg <= k_reg - 1'b1;
        end
        if (cmd.shift) begin
            a_reg <= (ip_reg >= 12'd32) ? '0 : 25'((p_reg >> 8) >> ip_reg[4:0]);
        end
        if (cmd.mul_y) begin
            neg_reg   <= env_reg[ENV_W-1];
            yprod_reg <= 57'(a_reg) * 57'(mag);
        end
        if (cmd.finish) begin
            m_chan_reg <= ch_reg;
            m_val_reg  <= y24;
        end
    end

    // Report status
    always_comb begin
        status.is_sample = sample_ok_reg;
        status.bypass    = ms_reg == '0;
        status.div_done  = div_done;
        status.k_last    = k_reg == 4'd1;
        status.out_free  = out_free;
    end

    assign m_valid       = m_valid_reg;
    assign m_out_channel = m_chan_reg;
    assign m_out_value   = m_val_reg;

    // A result is never written over one still waiting
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |-> (!m_valid_reg || m_ready))
        else $error("result register overwritten");

    // A finished item always shows up at the output
    a_finish_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> m_valid_reg)
        else $error("finished result not presented");

    // Clear drops every channel's state
    a_clear_all: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.load && s_opcode == OP_CLEAR) |=> (valid_reg == '0))
        else $error("clear left channel state valid");

endmodule

/* rtl/core/ted_controller.sv */
// Controller state machine sequencing one item through the datapath.
module ted_controller (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  ted_pkg::ted_status_t  status,
    output ted_pkg::ted_cmd_t     cmd
);
    import ted_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_DIVE_START,
        ST_DIVE_WAIT,
        ST_MUL_T,
        ST_MUL_P,
        ST_DIV_K,
        ST_UPD_P,
        ST_SHIFT,
        ST_MUL_Y,
        ST_FIN
    } state_t;

    state_t state_reg;
    state_t state_next;

    // Pick the next step
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:       if (s_valid) state_next = ST_PREP;
            ST_PREP: begin
                if (!status.is_sample) state_next = ST_IDLE;
                else if (status.bypass) state_next = ST_FIN;
                else state_next = ST_DIVE_START;
            end
            ST_DIVE_START: state_next = ST_DIVE_WAIT;
            ST_DIVE_WAIT:  if (status.div_done) state_next = ST_MUL_T;
            ST_MUL_T:      state_next = ST_MUL_P;
            ST_MUL_P:      state_next = ST_DIV_K;
            ST_DIV_K:      state_next = ST_UPD_P;
            ST_UPD_P:      state_next = status.k_last ? ST_SHIFT : ST_MUL_P;
            ST_SHIFT:      state_next = ST_MUL_Y;
            ST_MUL_Y:      state_next = ST_FIN;
            ST_FIN:        if (status.out_free) state_next = ST_IDLE;
            default:       state_next = ST_IDLE;
        endcase
    end

    // Hold state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Decode commands from state
    always_comb begin
        s_ready       = state_reg == ST_IDLE;
        cmd.load      = (state_reg == ST_IDLE) && s_valid;
        cmd.prep      = state_reg == ST_PREP;
        cmd.div_start = state_reg == ST_DIVE_START;
        cmd.div_k     = state_reg == ST_DIV_K;
        cmd.mul_t     = state_reg == ST_MUL_T;
        cmd.mul_p     = state_reg == ST_MUL_P;
        cmd.upd_p     = state_reg == ST_UPD_P;
        cmd.shift     = state_reg == ST_SHIFT;
        cmd.mul_y     = state_reg == ST_MUL_Y;
        cmd.finish    = (state_reg == ST_FIN) && status.out_free;
    end

endmodule

/* rtl/core/triggered_exponential_decay.sv */
// Top level of the triggered exponential decay envelope.
// Per-channel decay envelope with a 60 dB fall time given in ms. The block
// takes one item at a time. Messages (arm, arm with value, clear) pass
// through the load and prep steps only. A sample with decay_ms of zero goes
// from prep straight to the finish step. Any other sample needs one 36-bit
// pass of the serial divider for the exponent, begun by its start step, and
// an exp2 series of ten terms, each a multiply, a division by the term index
// done by a reciprocal multiply and an update. A finished result sits in the
// output register while the next item is accepted; the block stalls in its
// last step only if that register has not been taken yet.
module triggered_exponential_decay #(
    parameter int CHANNELS = ted_pkg::CHANNELS_DEFAULT
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [ted_pkg::OP_W-1:0]           s_opcode,
    input  logic [ted_pkg::CHAN_W-1:0]         s_channel,
    input  logic signed [ted_pkg::SAMP_W-1:0]  s_sample,
    input  logic [ted_pkg::MS_W-1:0]           s_decay_ms,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [ted_pkg::CHAN_W-1:0]         m_out_channel,
    output logic signed [ted_pkg::SAMP_W-1:0]  m_out_value,
    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic                               cfg_index,
    input  logic [ted_pkg::SR_W-1:0]           cfg_data
);
    import ted_pkg::*;

    ted_cmd_t    cmd;
    ted_status_t status;

    // Configuration writes are always taken
    assign cfg_ready = 1'b1;

    ted_controller u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    ted_datapath #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .s_opcode      (s_opcode),
        .s_channel     (s_channel),
        .s_sample      (s_sample),
        .s_decay_ms    (s_decay_ms),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_out_channel (m_out_channel),
        .m_out_value   (m_out_value)
    );

endmodule
